// ----- hdl/multichannel_weighted_pid_core_defines.svh -----
// Assertion macros for the weighted PID core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MULTICHANNEL_WEIGHTED_PID_CORE_DEFINES_SVH
`define MULTICHANNEL_WEIGHTED_PID_CORE_DEFINES_SVH

// same-cycle implication
`define MWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mwp_pkg.sv -----
// Shared types and constants for the weighted PID core.
// No dependencies; used by all other files but the defines header.
`timescale 1ns / 1ps

package mwp_pkg;

  localparam int DATA_W     = 32;
  localparam int CH_FIELD_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MASK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd2;

  localparam logic [15:0] WRAP_MASK_RST    = 16'd2064;
  localparam logic [9:0]  DEFAULT_STEP_RST = 10'd40;
  localparam logic [15:0] MAX_STEP_RST     = 16'd1000;

  // serial arithmetic units
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 34;
  localparam int PROD_W  = 64;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 48;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quo;
    logic [DIV_D_W-1:0] rem;
    logic               half_up;
  } div_rsp_t;

endpackage

// ----- hdl/mwp_in_if.sv -----
// Sample channel: valid/ready plus one sample's fields.
// Depends on mwp_pkg.
`timescale 1ns / 1ps

interface mwp_in_if;
  logic                                valid;
  logic                                ready;
  logic [mwp_pkg::CH_FIELD_W-1:0]      channel;
  logic signed [mwp_pkg::DATA_W-1:0]   target;
  logic signed [mwp_pkg::DATA_W-1:0]   measured;
  logic [mwp_pkg::DATA_W-1:0]          now_ms;
  logic signed [mwp_pkg::DATA_W-1:0]   gain_p;
  logic signed [mwp_pkg::DATA_W-1:0]   gain_i;
  logic signed [mwp_pkg::DATA_W-1:0]   gain_d;
  logic signed [mwp_pkg::DATA_W-1:0]   integral_floor;
  logic signed [mwp_pkg::DATA_W-1:0]   integral_ceiling;

  modport source (output valid, channel, target, measured, now_ms, gain_p, gain_i,
                  gain_d, integral_floor, integral_ceiling, input ready);
  modport sink (input valid, channel, target, measured, now_ms, gain_p, gain_i,
                gain_d, integral_floor, integral_ceiling, output ready);
endinterface

// ----- hdl/mwp_out_if.sv -----
// Result channel: valid/ready plus drive and clip flag.
// Depends on mwp_pkg.
`timescale 1ns / 1ps

interface mwp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwp_pkg::DATA_W-1:0] drive;
  logic                              clipped;

  modport source (output valid, drive, clipped, input ready);
  modport sink (input valid, drive, clipped, output ready);
endinterface

// ----- hdl/mwp_mul.sv -----
// Shift-add multiplier, one multiplier bit per clock, stops when no bits remain.
// Depends on mwp_pkg.
`timescale 1ns / 1ps

module mwp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  mwp_pkg::mul_req_t req,
  output mwp_pkg::mul_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [mwp_pkg::PROD_W-1:0]  acc_r;
  logic [mwp_pkg::PROD_W-1:0]  mcand_r;
  logic [mwp_pkg::MUL_B_W-1:0] mplier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        acc_r    <= '0;
        mcand_r  <= mwp_pkg::PROD_W'(req.a);
        mplier_r <= req.b;
      end else if (busy_r) begin
        if (mplier_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- hdl/mwp_div.sv -----
// Restoring divider, one quotient bit per clock, with a round-half-up flag.
// Depends on mwp_pkg.
`timescale 1ns / 1ps

module mwp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mwp_pkg::div_req_t req,
  output mwp_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(mwp_pkg::DIV_N_W);
  localparam int DW    = mwp_pkg::DIV_D_W;

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [mwp_pkg::DIV_N_W-1:0] dvd_r;
  logic [DW-1:0]               rem_r;
  logic [DW-1:0]               d_r;
  logic [DW:0]                 trial;
  logic                        ge;

  assign trial = {rem_r, dvd_r[mwp_pkg::DIV_N_W-1]};
  assign ge    = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.n;
        rem_r  <= '0;
        d_r    <= req.d;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
        dvd_r <= {dvd_r[mwp_pkg::DIV_N_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(mwp_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.quo     = dvd_r;
  assign rsp.rem     = rem_r;
  // round to nearest, ties up: 2*rem >= divisor
  assign rsp.half_up = ({rem_r, 1'b0} >= {1'b0, d_r});

endmodule

// ----- hdl/multichannel_weighted_pid_core.sv -----
// Multi-channel PID controller with setpoint weighting, Q(FRAC_BITS) fixed point.
// One sample is worked at a time; it passes through the bit-serial divider (one to four
// divisions) and the shift-add multiplier (up to seven products). The derivative
// path runs only on a channel's second and later samples, and the weight division
// only when the error is small against the setpoint. Results leave through an
// output register, so in_ch.ready returns while a result still waits; the next
// result then holds in its last state until that beat is taken. Per-channel state
// needs no clearing pass after reset.
// Depends on mwp_pkg, mwp_in_if, mwp_out_if, mwp_mul, mwp_div and the defines header.
`timescale 1ns / 1ps
`include "multichannel_weighted_pid_core_defines.svh"

module multichannel_weighted_pid_core #(
  parameter int NUM_CHANNELS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mwp_in_if.sink                           in_ch,
  mwp_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [mwp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mwp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WQ_W     = FRAC_BITS + 1;
  localparam int TERM_W   = 52;
  localparam int SUM_W    = 54;
  localparam int W_LOW_I  = ((4 << FRAC_BITS) + 2) / 5;

  localparam logic signed [34:0] HALF_TURN = 35'(180) << FRAC_BITS;
  localparam logic signed [34:0] FULL_TURN = 35'(360) << FRAC_BITS;
  localparam logic [31:0]        ONE32     = 32'(1) << FRAC_BITS;
  localparam logic [WQ_W-1:0]    ONE_W     = WQ_W'(1) << FRAC_BITS;
  localparam logic [WQ_W-1:0]    W_LOW     = WQ_W'(W_LOW_I);
  localparam logic [TERM_W-1:0]  TERM_CAP  = TERM_W'(1) << 50;
  localparam logic [41:0]        QUO_CAP   = 42'(1) << 41;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh80000000);
  localparam logic [mwp_pkg::MUL_B_W-1:0] MS_PER_S = 34'd1000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_WRAP, ST_ABS, ST_WSEL, ST_WDIV, ST_WMUL, ST_PSET, ST_PMUL,
    ST_IMUL1, ST_IDIV, ST_ISET, ST_IMUL2, ST_DMUL1, ST_DDIV1, ST_DMUL2, ST_DMUL3,
    ST_DDIV2, ST_SUM, ST_EMIT
  } state_t;

  function automatic logic [64:0] q_round(input logic [63:0] p);
    logic [64:0] t;
    t = {1'b0, p} + (65'd1 << (FRAC_BITS - 1));
    return t >> FRAC_BITS;
  endfunction

  function automatic logic [TERM_W-1:0] cap_term(input logic [64:0] m, input logic neg);
    logic [TERM_W-1:0] c;
    c = (m > 65'(TERM_CAP)) ? TERM_CAP : m[TERM_W-1:0];
    return neg ? (~c + 1'b1) : c;
  endfunction

  function automatic logic [35:0] abs36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  // configuration
  logic [15:0] wrap_mask_r;
  logic [9:0]  dflt_step_r;
  logic [15:0] max_step_r;

  // sample registers
  state_t             st_r;
  logic [3:0]         ch_r;
  logic [CH_W-1:0]    ch_idx_r;
  logic               inrange_r;
  logic signed [31:0] tgt_r, meas_r, kp_r, ki_r, kd_r, lo_r, hi_r;
  logic [31:0]        now_r;

  // per-channel state
  logic [NUM_CHANNELS-1:0] seen_r;
  logic [31:0]        stamp_mem [NUM_CHANNELS];
  logic signed [31:0] prior_mem [NUM_CHANNELS];
  logic signed [31:0] integ_mem [NUM_CHANNELS];
  logic [31:0]        stamp_q;
  logic signed [31:0] prior_q;
  logic signed [31:0] integ_q;
  logic               seen_q;

  // datapath
  logic signed [34:0] err_r;
  logic [31:0]        delta_r;
  logic [15:0]        dt_r;
  logic [33:0]        aerr_r;
  logic [31:0]        tabs_r;
  logic [31:0]        den_r;
  logic signed [33:0] errp_r;
  logic signed [32:0] diff_r;
  logic signed [42:0] isum_r;
  logic signed [31:0] integ_r;
  logic [47:0]        rem_r;
  logic [51:0]        dbase_r;
  logic [TERM_W-1:0]  pterm_r, iterm_r, dterm_r;
  logic signed [SUM_W-1:0] sum_r;

  logic               out_valid_r;
  logic signed [31:0] drive_r;
  logic               clip_r;

  mwp_pkg::mul_req_t mul_req_r;
  mwp_pkg::mul_rsp_t mul_rsp;
  mwp_pkg::div_req_t div_req_r;
  mwp_pkg::div_rsp_t div_rsp;

  mwp_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req_r), .rsp(mul_rsp));
  mwp_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .rsp(div_rsp));

  // combinational helpers
  logic               accept;
  logic [CH_W-1:0]    in_idx;
  logic               in_range;
  logic               wrap_on;
  logic [15:0]        dt_pick;
  logic [15:0]        dt_sel;
  logic [WQ_W-1:0]    w_c;
  logic [33:0]        wt_mag;
  logic signed [33:0] wt_s;
  logic [40:0]        incr_c;
  logic signed [31:0] integ_base;
  logic signed [31:0] integ_c;
  logic [41:0]        quo_cap_c;
  logic [64:0]        dm_c;
  logic [47:0]        dt_q;
  logic               emit_go;
  logic               mem_we;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_idx   = CH_W'(in_ch.channel);
  assign in_range = (32'(in_ch.channel) < 32'(NUM_CHANNELS));
  assign wrap_on  = wrap_mask_r[ch_r];

  // dt falls back on first sample, zero interval or interval above the limit
  assign dt_pick = (!seen_q || delta_r == '0 || delta_r > 32'(max_step_r))
                   ? 16'(dflt_step_r) : delta_r[15:0];
  assign dt_sel  = (dt_pick == '0) ? 16'd1 : dt_pick;
  assign dt_q    = 48'(dt_r) << FRAC_BITS;

  assign w_c     = ONE_W - (WQ_W'(div_rsp.quo) + WQ_W'(div_rsp.half_up));
  assign wt_mag  = 34'(q_round(mul_rsp.prod));
  assign wt_s    = tgt_r[31] ? -$signed(wt_mag) : $signed(wt_mag);

  assign incr_c     = 41'(div_rsp.quo) + 41'(div_rsp.half_up);
  assign integ_base = seen_q ? integ_q : 32'sd0;
  assign integ_c    = (isum_r < 43'(lo_r)) ? lo_r :
                      (isum_r > 43'(hi_r)) ? hi_r : isum_r[31:0];

  assign quo_cap_c = (div_rsp.quo > 64'(QUO_CAP)) ? QUO_CAP : div_rsp.quo[41:0];
  assign dm_c      = 65'(dbase_r) + 65'(div_rsp.quo) + 65'(div_rsp.half_up);

  assign emit_go = !out_valid_r || out_ch.ready;
  assign mem_we  = (st_r == ST_EMIT) && emit_go && inrange_r;

  assign in_ch.ready    = (st_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive   = drive_r;
  assign out_ch.clipped = clip_r;

  // per-channel memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[ch_idx_r] <= now_r;
      prior_mem[ch_idx_r] <= meas_r;
      integ_mem[ch_idx_r] <= integ_r;
    end
    if (accept) begin
      stamp_q <= stamp_mem[in_idx];
      prior_q <= prior_mem[in_idx];
      integ_q <= integ_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_IDLE;
      out_valid_r     <= 1'b0;
      seen_r          <= '0;
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      wrap_mask_r     <= mwp_pkg::WRAP_MASK_RST;
      dflt_step_r     <= mwp_pkg::DEFAULT_STEP_RST;
      max_step_r      <= mwp_pkg::MAX_STEP_RST;
    end else begin
      // start pulses last one clock; no state issues a request while its pulse is high
      if (mul_req_r.start) begin
        mul_req_r.start <= 1'b0;
      end
      if (div_req_r.start) begin
        div_req_r.start <= 1'b0;
      end
      // a new result in ST_EMIT takes the register over instead
      if (out_valid_r && out_ch.ready && st_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          mwp_pkg::CFG_WRAP_MASK:    wrap_mask_r <= cfg_wdata;
          mwp_pkg::CFG_DEFAULT_STEP: dflt_step_r <= cfg_wdata[9:0];
          mwp_pkg::CFG_MAX_STEP:     max_step_r  <= cfg_wdata;
          default: ;
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            ch_r      <= in_ch.channel;
            ch_idx_r  <= in_idx;
            inrange_r <= in_range;
            seen_q    <= in_range && seen_r[in_idx];
            tgt_r     <= in_ch.target;
            meas_r    <= in_ch.measured;
            now_r     <= in_ch.now_ms;
            kp_r      <= in_ch.gain_p;
            ki_r      <= in_ch.gain_i;
            kd_r      <= in_ch.gain_d;
            lo_r      <= in_ch.integral_floor;
            hi_r      <= in_ch.integral_ceiling;
            st_r      <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          err_r   <= 35'(tgt_r) - 35'(meas_r);
          delta_r <= now_r - stamp_q;
          diff_r  <= 33'(prior_q) - 33'(meas_r);
          if (inrange_r) begin
            st_r <= ST_WRAP;
          end else begin
            sum_r <= '0;
            st_r  <= ST_EMIT;
          end
        end
        ST_WRAP: begin
          if (wrap_on && err_r > HALF_TURN) begin
            err_r <= err_r - FULL_TURN;
          end else if (wrap_on && err_r < -HALF_TURN) begin
            err_r <= err_r + FULL_TURN;
          end
          dt_r <= dt_sel;
          st_r <= ST_ABS;
        end
        ST_ABS: begin
          aerr_r <= 34'(abs36(36'(err_r)));
          tabs_r <= 32'(abs36(36'(tgt_r)));
          den_r  <= (32'(abs36(36'(tgt_r))) < ONE32) ? ONE32 : 32'(abs36(36'(tgt_r)));
          st_r   <= ST_WSEL;
        end
        ST_WSEL: begin
          if (35'({aerr_r, 1'b0}) < 35'(den_r)) begin
            div_req_r <= '{start: 1'b1,
                           n: 64'({aerr_r, 1'b0}) << FRAC_BITS,
                           d: 48'(den_r) + (48'(den_r) << 2)};
            st_r <= ST_WDIV;
          end else begin
            mul_req_r <= '{start: 1'b1, a: 48'(W_LOW), b: 34'(tabs_r)};
            st_r      <= ST_WMUL;
          end
        end
        ST_WDIV: begin
          if (div_rsp.done) begin
            mul_req_r <= '{start: 1'b1, a: 48'(w_c), b: 34'(tabs_r)};
            st_r      <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          if (mul_rsp.done) begin
            errp_r <= wt_s - 34'(meas_r);
            st_r   <= ST_PSET;
          end
        end
        ST_PSET: begin
          mul_req_r <= '{start: 1'b1, a: 48'(abs36(36'(errp_r))),
                         b: 34'(abs36(36'(kp_r)))};
          st_r <= ST_PMUL;
        end
        ST_PMUL: begin
          if (mul_rsp.done) begin
            pterm_r   <= cap_term(q_round(mul_rsp.prod), errp_r[33] ^ kp_r[31]);
            mul_req_r <= '{start: 1'b1, a: 48'(aerr_r), b: 34'(dt_r)};
            st_r      <= ST_IMUL1;
          end
        end
        ST_IMUL1: begin
          if (mul_rsp.done) begin
            div_req_r <= '{start: 1'b1, n: mul_rsp.prod, d: 48'(MS_PER_S)};
            st_r      <= ST_IDIV;
          end
        end
        ST_IDIV: begin
          if (div_rsp.done) begin
            if (err_r[34]) begin
              isum_r <= 43'(integ_base) - 43'(incr_c);
            end else begin
              isum_r <= 43'(integ_base) + 43'(incr_c);
            end
            st_r <= ST_ISET;
          end
        end
        ST_ISET: begin
          integ_r   <= integ_c;
          mul_req_r <= '{start: 1'b1, a: 48'(abs36(36'(integ_c))),
                         b: 34'(abs36(36'(ki_r)))};
          st_r <= ST_IMUL2;
        end
        ST_IMUL2: begin
          if (mul_rsp.done) begin
            iterm_r <= cap_term(q_round(mul_rsp.prod), integ_r[31] ^ ki_r[31]);
            if (seen_q) begin
              mul_req_r <= '{start: 1'b1, a: 48'(abs36(36'(diff_r))),
                             b: 34'(abs36(36'(kd_r)))};
              st_r <= ST_DMUL1;
            end else begin
              dterm_r <= '0;
              st_r    <= ST_SUM;
            end
          end
        end
        ST_DMUL1: begin
          if (mul_rsp.done) begin
            div_req_r <= '{start: 1'b1, n: mul_rsp.prod, d: dt_q};
            st_r      <= ST_DDIV1;
          end
        end
        ST_DDIV1: begin
          if (div_rsp.done) begin
            rem_r     <= div_rsp.rem;
            mul_req_r <= '{start: 1'b1, a: 48'(quo_cap_c), b: MS_PER_S};
            st_r      <= ST_DMUL2;
          end
        end
        ST_DMUL2: begin
          if (mul_rsp.done) begin
            dbase_r   <= mul_rsp.prod[51:0];
            mul_req_r <= '{start: 1'b1, a: rem_r, b: MS_PER_S};
            st_r      <= ST_DMUL3;
          end
        end
        ST_DMUL3: begin
          if (mul_rsp.done) begin
            div_req_r <= '{start: 1'b1, n: mul_rsp.prod, d: dt_q};
            st_r      <= ST_DDIV2;
          end
        end
        ST_DDIV2: begin
          if (div_rsp.done) begin
            dterm_r <= cap_term(dm_c, diff_r[32] ^ kd_r[31]);
            st_r    <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r <= SUM_W'($signed(pterm_r)) + SUM_W'($signed(iterm_r))
                 + SUM_W'($signed(dterm_r));
          st_r  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            if (sum_r > SAT_HI) begin
              drive_r <= 32'sh7fffffff;
              clip_r  <= 1'b1;
            end else if (sum_r < SAT_LO) begin
              drive_r <= 32'sh80000000;
              clip_r  <= 1'b1;
            end else begin
              drive_r <= sum_r[31:0];
              clip_r  <= 1'b0;
            end
            if (inrange_r) begin
              seen_r[ch_idx_r] <= 1'b1;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `MWP_ASSERT_IMP(a_mul_start_idle, mul_req_r.start, !mul_rsp.busy, "mul started while busy")
  `MWP_ASSERT_IMP(a_div_start_idle, div_req_r.start, !div_rsp.busy, "div started while busy")
  `MWP_ASSERT_NXT(a_one_at_a_time, accept, !in_ch.ready, "second sample taken mid-flight")
  `MWP_ASSERT_IMP(a_clip_rails, out_ch.valid && out_ch.clipped, (out_ch.drive == 32'sh7fffffff || out_ch.drive == 32'sh80000000), "clip flag without rail value")

endmodule
